// ===== design/bmdf_pkg.sv =====
// Shared types, field widths, verdict and register codes for the bridged
// message dedup filter. No dependencies; imported by every design module.
package bmdf_pkg;

    localparam int DEDUP_DEPTH_DEF = 64;

    localparam int ID_W       = 32;
    localparam int TIME_W     = 32;
    localparam int TTL_W      = 8;
    localparam int BAND_W     = 4;
    localparam int PORT_W     = 10;
    localparam int PLEN_W     = 8;
    localparam int WINMIN_W   = 9;
    localparam int WIN_W      = 25;
    localparam int VERDICT_W  = 3;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_BAND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFUSED_PORT = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_BAD_ID    = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DUP       = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TTL       = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_SAME_BAND = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_RECORDED  = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_REFUSED   = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_REINJECT  = 3'd6;
    localparam logic [VERDICT_W-1:0] VERDICT_CLEANUP   = 3'd7;

    localparam logic [WINMIN_W-1:0] WIN_DEFAULT_MIN = 9'd60;
    localparam logic [WINMIN_W-1:0] WIN_LOW_MIN     = 9'd10;
    localparam logic [WINMIN_W-1:0] WIN_HIGH_MIN    = 9'd360;
    localparam logic [15:0]         MS_PER_MIN      = 16'd60000;
    localparam logic [COUNT_W-1:0]  COUNT_SAT       = 7'd127;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input word, restart the scan
        logic rd_en;     // read one store entry, advance the scan
        logic wipe;      // invalidate one store entry, advance the scan
        logic commit;    // record an admitted message
        logic out_load;  // move the verdict into the output register
    } bmdf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last; // the scan counter sits on the final entry
    } bmdf_sts_t;

    // Clamp the window in minutes and convert it to milliseconds
    function automatic logic [WIN_W-1:0] window_ms(input logic [WINMIN_W-1:0] minutes);
        logic [WINMIN_W-1:0] m;
        logic [WIN_W-1:0]    prod;
        m = minutes;
        if (m == '0) begin
            m = WIN_DEFAULT_MIN;
        end else if (m < WIN_LOW_MIN) begin
            m = WIN_LOW_MIN;
        end else if (m > WIN_HIGH_MIN) begin
            m = WIN_HIGH_MIN;
        end
        prod = WIN_W'(m) * WIN_W'(MS_PER_MIN);
        return prod;
    endfunction

endpackage

// ===== design/bmdf_ctrl.sv =====
// Sequencer for the dedup filter: reset clearing pass, store scan, commit
// and result handoff. Depends on bmdf_pkg for the command and status structs.
module bmdf_ctrl
    import bmdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output bmdf_cmd_t cmd,
    input  bmdf_sts_t sts
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wipe = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // last read word is evaluated here
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    a_valid_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("output valid rose outside the result state");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    a_no_output_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && !s_ready))
        else $error("handshake active during clearing pass");

endmodule

// ===== design/bmdf_datapath.sv =====
// Datapath for the dedup filter: config registers, entry store memory, scan
// evaluation, slot choice and result register. Depends on bmdf_pkg.
module bmdf_datapath
    import bmdf_pkg::*;
#(
    parameter int DEDUP_DEPTH = DEDUP_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bmdf_cmd_t             cmd,
    output bmdf_sts_t             sts,
    input  logic                  s_command,
    input  logic [TIME_W-1:0]     s_now_ms,
    input  logic [ID_W-1:0]       s_message_id,
    input  logic [TTL_W-1:0]      s_hop_budget,
    input  logic [BAND_W-1:0]     s_source_band,
    input  logic [PORT_W-1:0]     s_app_port,
    input  logic [PLEN_W-1:0]     s_payload_bytes,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [VERDICT_W-1:0]  m_verdict,
    output logic                  m_reinject,
    output logic                  m_publish,
    output logic [COUNT_W-1:0]    m_removed_count
);

    localparam int               IDX_W    = $clog2(DEDUP_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEDUP_DEPTH - 1);

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   id;
    } entry_t;

    // configuration
    logic [BAND_W-1:0] own_band_reg;
    logic [WIN_W-1:0]  win_ms_reg;
    logic [PORT_W-1:0] refused_port_reg;

    // captured input word
    logic              is_cleanup_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TTL_W-1:0]  ttl_reg;
    logic [BAND_W-1:0] band_reg;
    logic [PORT_W-1:0] port_reg;
    logic [PLEN_W-1:0] plen_reg;

    // scan pointers and read pipeline
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_valid_reg;
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] write_slot_reg, write_slot_next;

    // scan results
    logic               dup_reg, dup_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_slot_reg, free_slot_next;
    logic               have_old_reg, have_old_next;
    logic [IDX_W-1:0]   old_slot_reg, old_slot_next;
    logic [TIME_W-1:0]  best_age_reg, best_age_next;
    logic [COUNT_W-1:0] removed_reg, removed_next;

    // result register
    logic [VERDICT_W-1:0] verdict_reg;
    logic                 reinject_reg;
    logic                 publish_reg;
    logic [COUNT_W-1:0]   count_reg;

    entry_t store_mem [DEDUP_DEPTH];

    logic [TIME_W-1:0]    age;
    logic                 hit_dup, hit_free, hit_old, hit_exp;
    logic                 admitted;
    logic [IDX_W-1:0]     pick;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;
    logic [VERDICT_W-1:0] verdict_c;
    logic                 reinject_c, publish_c;

    assign sts.scan_last = (cnt_reg == LAST_IDX);

    // evaluate the word read in the previous cycle
    always_comb begin
        age      = now_reg - rd_data_reg.stamp;
        hit_dup  = rd_valid_reg && !is_cleanup_reg && rd_data_reg.valid
                   && (rd_data_reg.id == id_reg);
        hit_free = rd_valid_reg && !is_cleanup_reg && !rd_data_reg.valid && !free_found_reg;
        hit_old  = rd_valid_reg && !is_cleanup_reg && (!have_old_reg || age > best_age_reg);
        hit_exp  = rd_valid_reg && is_cleanup_reg && rd_data_reg.valid
                   && (age > {{(TIME_W - WIN_W){1'b0}}, win_ms_reg});
    end

    assign admitted = !is_cleanup_reg && (id_reg != '0) && !dup_reg && (ttl_reg != '0)
                      && (band_reg != own_band_reg);
    assign pick     = free_found_reg ? free_slot_reg : old_slot_reg;

    always_comb begin
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        write_slot_next = write_slot_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        have_old_next   = have_old_reg;
        old_slot_next   = old_slot_reg;
        best_age_next   = best_age_reg;
        removed_next    = removed_reg;

        if (cmd.load) begin
            cnt_next        = '0;
            addr_next       = s_command ? '0 : write_slot_reg;
            dup_next        = 1'b0;
            free_found_next = 1'b0;
            have_old_next   = 1'b0;
            removed_next    = '0;
        end else if (cmd.rd_en || cmd.wipe) begin
            cnt_next  = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
        end

        if (hit_dup) begin
            dup_next = 1'b1;
        end
        if (hit_free) begin
            free_found_next = 1'b1;
            free_slot_next  = rd_addr_reg;
        end
        if (hit_old) begin
            have_old_next = 1'b1;
            old_slot_next = rd_addr_reg;
            best_age_next = age;
        end
        if (hit_exp && (removed_reg != COUNT_SAT)) begin
            removed_next = removed_reg + 1'b1;
        end

        // advance the write slot one past the recorded entry
        if (cmd.commit && admitted) begin
            write_slot_next = (pick == LAST_IDX) ? '0 : pick + 1'b1;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.wipe) begin
            mem_we = 1'b1;
        end else if (hit_exp) begin
            mem_we          = 1'b1;
            mem_waddr       = rd_addr_reg;
            mem_wdata       = rd_data_reg;
            mem_wdata.valid = 1'b0;
        end else if (cmd.commit && admitted) begin
            mem_we          = 1'b1;
            mem_waddr       = pick;
            mem_wdata.valid = 1'b1;
            mem_wdata.stamp = now_reg;
            mem_wdata.id    = id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= store_mem[addr_reg];
        end
    end

    always_comb begin
        verdict_c  = VERDICT_RECORDED;
        reinject_c = 1'b0;
        publish_c  = 1'b0;
        if (is_cleanup_reg) begin
            verdict_c = VERDICT_CLEANUP;
        end else if (id_reg == '0) begin
            verdict_c = VERDICT_BAD_ID;
        end else if (dup_reg) begin
            verdict_c = VERDICT_DUP;
        end else if (ttl_reg == '0) begin
            verdict_c = VERDICT_TTL;
        end else if (band_reg == own_band_reg) begin
            verdict_c = VERDICT_SAME_BAND;
        end else if ((plen_reg != '0) && (port_reg != '0)) begin
            if (port_reg == refused_port_reg) begin
                verdict_c = VERDICT_REFUSED;
            end else begin
                verdict_c  = VERDICT_REINJECT;
                reinject_c = 1'b1;
                publish_c  = 1'b1;
            end
        end else begin
            verdict_c = VERDICT_RECORDED;
            publish_c = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_band_reg     <= '0;
            win_ms_reg       <= window_ms('0);
            refused_port_reg <= '0;
            cnt_reg          <= '0;
            addr_reg         <= '0;
            rd_valid_reg     <= 1'b0;
            write_slot_reg   <= '0;
            dup_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            have_old_reg     <= 1'b0;
            removed_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_OWN_BAND:     own_band_reg     <= cfg_data[BAND_W-1:0];
                    CFG_WINDOW:       win_ms_reg       <= window_ms(cfg_data[WINMIN_W-1:0]);
                    CFG_REFUSED_PORT: refused_port_reg <= cfg_data[PORT_W-1:0];
                    default: ;
                endcase
            end
            cnt_reg        <= cnt_next;
            addr_reg       <= addr_next;
            rd_valid_reg   <= cmd.rd_en;
            write_slot_reg <= write_slot_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            have_old_reg   <= have_old_next;
            removed_reg    <= removed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_cleanup_reg <= s_command;
            now_reg        <= s_now_ms;
            id_reg         <= s_message_id;
            ttl_reg        <= s_hop_budget;
            band_reg       <= s_source_band;
            port_reg       <= s_app_port;
            plen_reg       <= s_payload_bytes;
        end
        rd_addr_reg   <= addr_reg;
        free_slot_reg <= free_slot_next;
        old_slot_reg  <= old_slot_next;
        best_age_reg  <= best_age_next;
        if (cmd.out_load) begin
            verdict_reg  <= verdict_c;
            reinject_reg <= reinject_c;
            publish_reg  <= publish_c;
            count_reg    <= is_cleanup_reg ? removed_reg : '0;
        end
    end

    assign m_verdict       = verdict_reg;
    assign m_reinject      = reinject_reg;
    assign m_publish       = publish_reg;
    assign m_removed_count = count_reg;

    a_commit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !rd_valid_reg && !cmd.rd_en)
        else $error("commit overlaps the store scan");

    a_removed_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(removed_reg) <= DEDUP_DEPTH)
        else $error("removed count exceeds store depth");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(write_slot_reg) < DEDUP_DEPTH && int'(addr_reg) < DEDUP_DEPTH)
        else $error("store index out of range");

endmodule

// ===== design/bridged_message_dedup_filter.sv =====
// An accepted word is captured, then the store is scanned one entry per cycle through
// the memory read port, and the drain, commit and result states follow; s_ready stays
// low until the result has moved into the output register, so one word is in flight.
// Reset: synchronous, active low; a clearing pass over every store entry then
// holds s_ready low. cfg_ready is always high.
module bridged_message_dedup_filter
    import bmdf_pkg::*;
#(
    parameter int DEDUP_DEPTH = DEDUP_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [TIME_W-1:0]     s_now_ms,
    input  logic [ID_W-1:0]       s_message_id,
    input  logic [TTL_W-1:0]      s_hop_budget,
    input  logic [BAND_W-1:0]     s_source_band,
    input  logic [PORT_W-1:0]     s_app_port,
    input  logic [PLEN_W-1:0]     s_payload_bytes,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VERDICT_W-1:0]  m_verdict,
    output logic                  m_reinject,
    output logic                  m_publish,
    output logic [COUNT_W-1:0]    m_removed_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bmdf_cmd_t cmd;
    bmdf_sts_t sts;

    assign cfg_ready = 1'b1;

    bmdf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bmdf_datapath #(
        .DEDUP_DEPTH (DEDUP_DEPTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_command       (s_command),
        .s_now_ms        (s_now_ms),
        .s_message_id    (s_message_id),
        .s_hop_budget    (s_hop_budget),
        .s_source_band   (s_source_band),
        .s_app_port      (s_app_port),
        .s_payload_bytes (s_payload_bytes),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_verdict       (m_verdict),
        .m_reinject      (m_reinject),
        .m_publish       (m_publish),
        .m_removed_count (m_removed_count)
    );

endmodule

// ===== bench/bridged_message_dedup_filter_test.sv =====
// Self-checking bench for the bridged message dedup filter: directed admission
// cases, store overflow and random traffic under sender and receiver stalls.
// Depends on bmdf_pkg and the bridged_message_dedup_filter RTL only.
module bridged_message_dedup_filter_test
    import bmdf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEDUP_DEPTH_DEF;
    localparam int STUCK_LIMIT = 3000;
    localparam int REPORT_CAP = 100;

    typedef struct {
        logic                command;
        logic [TIME_W-1:0]   now_ms;
        logic [ID_W-1:0]     msg_id;
        logic [TTL_W-1:0]    hops;
        logic [BAND_W-1:0]   band;
        logic [PORT_W-1:0]   port;
        logic [PLEN_W-1:0]   plen;
    } bridged_msg_t;

    typedef struct {
        logic [VERDICT_W-1:0] verdict;
        logic                 reinject;
        logic                 publish;
        logic [COUNT_W-1:0]   removed;
    } admit_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = 1'b0;
    logic [TIME_W-1:0]     s_now_ms = '0;
    logic [ID_W-1:0]       s_message_id = '0;
    logic [TTL_W-1:0]      s_hop_budget = '0;
    logic [BAND_W-1:0]     s_source_band = '0;
    logic [PORT_W-1:0]     s_app_port = '0;
    logic [PLEN_W-1:0]     s_payload_bytes = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [VERDICT_W-1:0]  m_verdict;
    logic                  m_reinject;
    logic                  m_publish;
    logic [COUNT_W-1:0]    m_removed_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: dedup store and registers as the block should hold them
    logic [ID_W-1:0]     held_ids [DEPTH];
    logic [TIME_W-1:0]   held_stamps [DEPTH];
    bit                  held_live [DEPTH];
    int                  next_slot = 0;
    logic [BAND_W-1:0]   own_band_q = '0;
    logic [WINMIN_W-1:0] window_min_q = '0;
    logic [PORT_W-1:0]   refused_q = '0;

    admit_result_t pending_verdicts [$];
    int            error_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic [31:0]   clock_ms = '0;
    int            step_max_ms = 1000;

    bridged_message_dedup_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_now_ms(s_now_ms), .s_message_id(s_message_id), .s_hop_budget(s_hop_budget),
        .s_source_band(s_source_band), .s_app_port(s_app_port),
        .s_payload_bytes(s_payload_bytes),
        .m_valid(m_valid), .m_ready(m_ready), .m_verdict(m_verdict),
        .m_reinject(m_reinject), .m_publish(m_publish), .m_removed_count(m_removed_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        // keep the log short when everything goes wrong
        if (error_count <= REPORT_CAP)
            $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic admit_result_t predict_admission(input bridged_msg_t m);
        admit_result_t r;
        int unsigned   minutes;
        logic [31:0]   limit_ms;
        logic [31:0]   age;
        logic [31:0]   oldest;
        int            removed;
        int            slot;
        int            pick;
        bit            held;
        bit            found;
        r = '{VERDICT_BAD_ID, 1'b0, 1'b0, '0};
        held = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (held_live[i] && held_ids[i] == m.msg_id) held = 1'b1;
        if (m.command) begin
            minutes = 32'(window_min_q);
            if (minutes == 0) minutes = 60;
            minutes = (minutes < 10) ? 10 : (minutes > 360) ? 360 : minutes;
            limit_ms = minutes * 60000;
            removed = 0;
            for (int i = 0; i < DEPTH; i++) begin
                age = m.now_ms - held_stamps[i];
                if (held_live[i] && age > limit_ms) begin
                    held_live[i] = 1'b0;
                    if (removed < 127) removed++;
                end
            end
            r.verdict = VERDICT_CLEANUP;
            r.removed = COUNT_W'(removed);
        end else if (m.msg_id == '0) begin
            r.verdict = VERDICT_BAD_ID;
        end else if (held) begin
            r.verdict = VERDICT_DUP;
        end else if (m.hops == '0) begin
            r.verdict = VERDICT_TTL;
        end else if (m.band == own_band_q) begin
            r.verdict = VERDICT_SAME_BAND;
        end else begin
            // first free slot from the write pointer, else the oldest entry
            pick = next_slot;
            found = 1'b0;
            for (int k = 0; k < DEPTH && !found; k++) begin
                slot = (next_slot + k) % DEPTH;
                if (!held_live[slot]) begin
                    pick = slot;
                    found = 1'b1;
                end
            end
            if (!found) begin
                oldest = '0;
                for (int k = 0; k < DEPTH; k++) begin
                    slot = (next_slot + k) % DEPTH;
                    age = m.now_ms - held_stamps[slot];
                    if (k == 0 || age > oldest) begin
                        oldest = age;
                        pick = slot;
                    end
                end
            end
            held_ids[pick] = m.msg_id;
            held_stamps[pick] = m.now_ms;
            held_live[pick] = 1'b1;
            next_slot = (pick + 1) % DEPTH;
            if (m.plen != '0 && m.port != '0) begin
                if (m.port == refused_q) begin
                    r.verdict = VERDICT_REFUSED;
                end else begin
                    r.verdict = VERDICT_REINJECT;
                    r.reinject = 1'b1;
                    r.publish = 1'b1;
                end
            end else begin
                r.verdict = VERDICT_RECORDED;
                r.publish = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : result_check
        admit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result word with nothing pending", 32'(m_verdict), '0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_verdict !== want.verdict)
                    report_mismatch("verdict", 32'(m_verdict), 32'(want.verdict));
                if (m_reinject !== want.reinject)
                    report_mismatch("reinject", 32'(m_reinject), 32'(want.reinject));
                if (m_publish !== want.publish)
                    report_mismatch("publish", 32'(m_publish), 32'(want.publish));
                if (m_removed_count !== want.removed)
                    report_mismatch("removed_count", 32'(m_removed_count),
                                    32'(want.removed));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t ns: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic drain();
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic send_word(input bridged_msg_t m);
        // leave the step of the previous handshake before raising valid again
        @(posedge aclk);
        if (send_idle_pct > 0 && $urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 80)) @(posedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_command <= m.command;
        s_now_ms <= m.now_ms;
        s_message_id <= m.msg_id;
        s_hop_budget <= m.hops;
        s_source_band <= m.band;
        s_app_port <= m.port;
        s_payload_bytes <= m.plen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        pending_verdicts.insert(pending_verdicts.size(), predict_admission(m));
    endtask

    task automatic load_settings(input logic [BAND_W-1:0] band,
                                 input logic [WINMIN_W-1:0] minutes,
                                 input logic [PORT_W-1:0] port);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] values [3];
        drain();
        regs = '{CFG_OWN_BAND, CFG_WINDOW, CFG_REFUSED_PORT};
        values = '{CFG_DATA_W'(band), CFG_DATA_W'(minutes), CFG_DATA_W'(port)};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= values[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (regs[i])
                CFG_OWN_BAND: begin
                    own_band_q = values[i][BAND_W-1:0];
                end
                CFG_WINDOW: begin
                    window_min_q = values[i][WINMIN_W-1:0];
                end
                default: begin
                    refused_q = values[i][PORT_W-1:0];
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic bridged_msg_t message(input logic [31:0] now, input logic [31:0] id,
                                             input logic [7:0] hops, input logic [3:0] band,
                                             input logic [9:0] port, input logic [7:0] plen);
        bridged_msg_t m;
        m = '{1'b0, now, id, hops, band, port, plen};
        return m;
    endfunction

    // message fields of a cleanup word are don't-care, so fill them with noise
    function automatic bridged_msg_t sweep(input logic [31:0] now);
        bridged_msg_t m;
        m = '{1'b1, now, $urandom(), TTL_W'($urandom()), BAND_W'($urandom()),
              PORT_W'($urandom()), PLEN_W'($urandom())};
        return m;
    endfunction

    function automatic bridged_msg_t random_message(input int id_pool);
        bridged_msg_t m;
        int           roll;
        clock_ms += $urandom_range(0, step_max_ms);
        m = sweep(clock_ms);
        m.command = ($urandom_range(0, 99) < 8);
        if ($urandom_range(0, 24) == 0) m.now_ms = $urandom();
        m.msg_id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, id_pool);
        if ($urandom_range(0, 29) == 0) m.msg_id = '0;
        m.hops = ($urandom_range(0, 19) == 0) ? '0 : TTL_W'($urandom_range(1, 255));
        roll = $urandom_range(0, 9);
        m.port = (roll == 0) ? refused_q : (roll == 1) ? '0 : PORT_W'($urandom_range(1, 1023));
        if ($urandom_range(0, 9) == 0) m.plen = '0;
        return m;
    endfunction

    task automatic test_admission_rules();
        load_settings(4'd5, 9'd0, 10'd77);
        send_word(message(32'd1000, 32'd0, 8'd1, 4'd1, 10'd1, 8'd1));
        send_word(message(32'd1000, 32'd1, 8'd1, 4'd1, 10'd1, 8'd1));
        send_word(message(32'd1001, 32'd1, 8'd9, 4'd2, 10'd3, 8'd4));
        send_word(message(32'd1002, 32'd2, 8'd0, 4'd1, 10'd1, 8'd1));
        send_word(message(32'd1003, 32'd3, 8'd1, 4'd5, 10'd1, 8'd1));
        send_word(message(32'd1004, 32'd4, 8'd1, 4'd1, 10'd9, 8'd0));
        send_word(message(32'd1005, 32'd5, 8'd1, 4'd1, 10'd0, 8'd9));
        send_word(message(32'd1006, 32'd6, 8'd1, 4'd1, 10'd77, 8'd9));
        send_word(message(32'd1007, 32'd6, 8'd1, 4'd1, 10'd10, 8'd9));
        send_word(message(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 10'h3FF, 8'hFF));
        send_word(sweep(32'd2000));
        send_word(sweep(32'd3_601_001));
        send_word(message(32'd3_601_002, 32'd1, 8'd1, 4'd1, 10'd1, 8'd1));
    endtask

    task automatic test_unknown_band_and_port_zero();
        load_settings(4'd0, 9'd360, 10'd0);
        send_word(message(32'd4_000_000, 32'd100, 8'd1, 4'd0, 10'd5, 8'd5));
        send_word(message(32'd4_000_001, 32'd101, 8'd1, 4'd4, 10'd0, 8'd5));
    endtask

    task automatic test_window_edges();
        // three minutes clamps to ten: an age of exactly 600000 ms survives
        load_settings(4'd0, 9'd3, 10'd0);
        send_word(message(32'd5_000_000, 32'd200, 8'd1, 4'd2, 10'd3, 8'd4));
        send_word(sweep(32'd5_600_000));
        send_word(sweep(32'd5_600_001));
        send_word(message(32'hFFFF_FFF0, 32'd201, 8'd1, 4'd2, 10'd3, 8'd4));
        send_word(sweep(32'h0000_0010));
        send_word(sweep(32'd600_000));
        load_settings(4'd15, 9'd511, 10'd1023);
        send_word(message(32'd700_000, 32'd300, 8'd1, 4'd15, 10'd1023, 8'd1));
        send_word(message(32'd700_001, 32'd301, 8'd1, 4'd14, 10'd1023, 8'd1));
        send_word(sweep(32'd700_002));
    endtask

    task automatic test_store_overflow();
        logic [31:0] base;
        load_settings(4'd0, 9'd360, 10'd0);
        base = $urandom();
        // groups of three share a stamp so eviction has ties to resolve
        for (int i = 0; i < 80; i++)
            send_word(message(base + (i / 3) * 1000, 32'h1000_0000 + i, 8'd1,
                              BAND_W'($urandom_range(1, 15)), PORT_W'($urandom()),
                              PLEN_W'($urandom())));
        for (int i = 0; i < 24; i++)
            send_word(message(base + 30_000 + i, 32'h1000_0000 + $urandom_range(0, 79), 8'd1,
                              4'd1, 10'd2, 8'd3));
        send_word(sweep(base + 22_000_000));
    endtask

    task automatic test_random_traffic(input logic [BAND_W-1:0] band,
                                       input logic [WINMIN_W-1:0] minutes,
                                       input logic [PORT_W-1:0] port,
                                       input int idle_pct, input int stall_pct,
                                       input int step_max, input int words);
        load_settings(band, minutes, port);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        step_max_ms = step_max;
        clock_ms = $urandom();
        for (int i = 0; i < words; i++) begin
            // now and then hold off until every result is back
            if ($urandom_range(0, 59) == 0) drain();
            send_word(random_message(150));
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_admission_rules();
        test_unknown_band_and_port_zero();
        test_window_edges();
        test_store_overflow();
        test_random_traffic(4'd0, 9'd0, 10'd0, 0, 0, 200_000, 330);
        test_random_traffic(4'd15, 9'd511, 10'd1023, 75, 0, 2_000_000, 330);
        test_random_traffic(4'd7, 9'd9, 10'd513, 0, 75, 100_000, 330);
        test_random_traffic(4'd3, 9'd10, 10'd1, 25, 25, 300_000, 330);
        drain();
        // catch any stray result words
        repeat (DEPTH + 8) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
